@@ rtl/text_console_cell_writer_macros.svh @@
// Assertion macros for the text console cell writer.
// Both macros expect signals named clk and rst_n in the module that uses them.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCCW_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCCW_ASSERT_IMPLY(name, ante, cons, msg)
`define TCCW_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ rtl/tccw_pkg.sv @@
`timescale 1ns / 1ps
package tccw_pkg;

  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_ROWS_DEF    = 25;
  localparam int POS_W              = 12;

  localparam logic [7:0] NEWLINE_CODE       = 8'h0A;
  localparam logic [7:0] ERROR_MARK         = 8'h45;
  localparam logic [7:0] BLANK_CODE         = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h0F;

  typedef enum logic [1:0] {
    OP_PUT_CURSOR = 2'd0,
    OP_PUT_AT     = 2'd1,
    OP_READ       = 2'd2,
    OP_SET_CURSOR = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] row;
    logic [6:0] column;
    logic [7:0] char_code;
    logic [7:0] char_attr;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       error;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CLEAR,
    MODE_EXEC,
    MODE_COPY,
    MODE_BLANK
  } mode_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_COLS,
    PTR_BOTTOM
  } ptr_src_t;

  typedef struct packed {
    mode_t    mode;
    ptr_src_t ptr_src;
    logic     capture;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scroll_needed;
    logic ptr_last;
  } dp_status_t;

endpackage

@@ rtl/text_console_cell_writer.sv @@
`timescale 1ns / 1ps
// An ordinary item raises out_valid after states EXEC and DONE: execute, then load result,
// where DONE waits until the previous result is taken. A new item is accepted only in IDLE.
// A put that takes the cursor past the last row adds the scroll copy, drain and blank.
// Synchronous active-low reset starts a clearing pass over all ROWS*COLUMNS cells of the
// screen memory with in_ready low; configuration writes are taken during it.
`include "text_console_cell_writer_macros.svh"
module text_console_cell_writer import tccw_pkg::*; #(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       cursor_on_screen;
  logic       cell_data_zero;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tccw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

  assign cursor_on_screen = ({1'b0, out_item.cursor_row} < 6'(SCREEN_ROWS)) &&
                            ({1'b0, out_item.cursor_column} < 8'(SCREEN_COLUMNS));
  assign cell_data_zero   = (out_item.cell_char == 8'd0) && (out_item.cell_attr == 8'd0);

  `TCCW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `TCCW_ASSERT_IMPLY(a_cursor_on_screen, out_valid, cursor_on_screen, "cursor off screen")
  `TCCW_ASSERT_IMPLY(a_error_no_data, out_valid && out_item.error, cell_data_zero, "cell data with error")

endmodule

@@ rtl/tccw_datapath.sv @@
`timescale 1ns / 1ps
module tccw_datapath import tccw_pkg::*; #(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  in_item_t   in_item,
  output out_item_t  out_item,
  input  dp_cmd_t    cmd,
  output dp_status_t st
);

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELLS - SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_ADDR   = ADDR_W'(SCREEN_COLUMNS);

  logic [15:0] mem [CELLS];

  in_item_t    item_r;
  logic [7:0]  default_attr_r;
  logic [4:0]  cur_row_r;
  logic [6:0]  cur_col_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W-1:0] ptr_nxt;
  logic        cp_wv_r;
  logic [ADDR_W-1:0] cp_wa_r;
  logic [15:0] rdata_r;
  logic        res_err_r;
  logic        res_rd_r;
  out_item_t   out_r;

  logic        outside;
  logic        at_cursor;
  logic [4:0]  base_row;
  logic [6:0]  base_col;
  logic [POS_W-1:0] pos_full;
  logic [ADDR_W-1:0] pos;
  logic        is_put;
  logic        newline;
  logic [7:0]  col_inc;
  logic [5:0]  row_inc;
  logic        wrap;
  logic [5:0]  nxt_row;
  logic [6:0]  nxt_col;
  logic        scroll;
  logic [7:0]  attr_eff;

  logic        wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0] wr_data;
  logic        rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign outside   = ({1'b0, item_r.row} >= 6'(SCREEN_ROWS)) ||
                     ({1'b0, item_r.column} >= 8'(SCREEN_COLUMNS));
  assign at_cursor = (item_r.op == OP_PUT_CURSOR);
  assign base_row  = at_cursor ? cur_row_r : item_r.row;
  assign base_col  = at_cursor ? cur_col_r : item_r.column;
  assign pos_full  = POS_W'(base_row) * POS_W'(SCREEN_COLUMNS) + POS_W'(base_col);
  assign pos       = pos_full[ADDR_W-1:0];
  assign is_put    = at_cursor || ((item_r.op == OP_PUT_AT) && !outside);
  assign newline   = (item_r.char_code == NEWLINE_CODE);
  assign col_inc   = {1'b0, base_col} + 8'd1;
  assign row_inc   = {1'b0, base_row} + 6'd1;
  assign wrap      = newline || (col_inc == 8'(SCREEN_COLUMNS));
  assign nxt_row   = wrap ? row_inc : {1'b0, base_row};
  assign nxt_col   = wrap ? 7'd0 : col_inc[6:0];
  assign scroll    = is_put && (nxt_row == 6'(SCREEN_ROWS));
  assign attr_eff  = (item_r.char_attr == 8'd0) ? default_attr_r : item_r.char_attr;

  assign st.scroll_needed = scroll;
  assign st.ptr_last      = (ptr_r == LAST_ADDR);
  assign out_item         = out_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = ptr_r;
    unique case (cmd.mode)
      MODE_IDLE: begin
      end
      MODE_CLEAR: begin
        wr_en = 1'b1;
      end
      MODE_EXEC: begin
        if (is_put && !newline) begin
          wr_en   = 1'b1;
          wr_addr = pos;
          wr_data = {attr_eff, item_r.char_code};
        end else if ((item_r.op == OP_PUT_AT) && outside) begin
          wr_en   = 1'b1;
          wr_addr = LAST_ADDR;
          wr_data = {default_attr_r, ERROR_MARK};
        end
        if ((item_r.op == OP_READ) && !outside) begin
          rd_en   = 1'b1;
          rd_addr = pos;
        end
      end
      MODE_COPY: begin
        rd_en = 1'b1;
      end
      MODE_BLANK: begin
        wr_en   = 1'b1;
        wr_data = {default_attr_r, BLANK_CODE};
      end
      default: begin
      end
    endcase
    if (cp_wv_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_wa_r;
      wr_data = rdata_r;
    end
  end

  always_comb begin
    unique case (cmd.ptr_src)
      PTR_HOLD:   ptr_nxt = ptr_r;
      PTR_INC:    ptr_nxt = ptr_r + ADDR_W'(1);
      PTR_COLS:   ptr_nxt = COLS_ADDR;
      PTR_BOTTOM: ptr_nxt = BOTTOM_ADDR;
      default:    ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= DEFAULT_ATTR_RESET;
      cur_row_r      <= '0;
      cur_col_r      <= '0;
      ptr_r          <= '0;
      cp_wv_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_attr_r <= cfg_wdata;
      end
      ptr_r   <= ptr_nxt;
      cp_wv_r <= (cmd.mode == MODE_COPY);
      if (cmd.mode == MODE_EXEC) begin
        if (is_put) begin
          if (scroll) begin
            cur_row_r <= 5'(SCREEN_ROWS - 1);
            cur_col_r <= '0;
          end else begin
            cur_row_r <= nxt_row[4:0];
            cur_col_r <= nxt_col;
          end
        end else if ((item_r.op == OP_SET_CURSOR) && !outside) begin
          cur_row_r <= item_r.row;
          cur_col_r <= item_r.column;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    cp_wa_r <= ptr_r - COLS_ADDR;
    if (cmd.mode == MODE_EXEC) begin
      res_err_r <= (item_r.op != OP_PUT_CURSOR) && outside;
      res_rd_r  <= (item_r.op == OP_READ) && !outside;
    end
    if (cmd.load_out) begin
      out_r.cursor_row    <= cur_row_r;
      out_r.cursor_column <= cur_col_r;
      out_r.cell_char     <= res_rd_r ? rdata_r[7:0] : 8'd0;
      out_r.cell_attr     <= res_rd_r ? rdata_r[15:8] : 8'd0;
      out_r.error         <= res_err_r;
    end
  end

endmodule

@@ rtl/tccw_ctrl.sv @@
`timescale 1ns / 1ps
module tccw_ctrl import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_DRAIN,
    S_BLANK,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '{mode: MODE_IDLE, ptr_src: PTR_HOLD, capture: 1'b0, load_out: 1'b0};
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.mode    = MODE_CLEAR;
        cmd.ptr_src = PTR_INC;
        if (st.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.mode = MODE_EXEC;
        if (st.scroll_needed) begin
          cmd.ptr_src = PTR_COLS;
          state_nxt   = S_COPY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_COPY: begin
        cmd.mode    = MODE_COPY;
        cmd.ptr_src = PTR_INC;
        if (st.ptr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.ptr_src = PTR_BOTTOM;
        state_nxt   = S_BLANK;
      end
      S_BLANK: begin
        cmd.mode    = MODE_BLANK;
        cmd.ptr_src = PTR_INC;
        if (st.ptr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
